/* rtl/core/worker_queue_with_liveness_top_defines.svh */
// ----------------------------------------------------------------------------
// Worker queue assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef WORKER_QUEUE_WITH_LIVENESS_TOP_DEFINES_SVH
`define WORKER_QUEUE_WITH_LIVENESS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// cond must hold at every clock edge outside reset
`define WQL_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("worker queue assertion failed");
// post must hold in the cycle after pre
`define WQL_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("worker queue assertion failed");
`else
`define WQL_ASSERT_ALWAYS(name, clk, rst, cond)
`define WQL_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

/* rtl/core/wql_pkg.sv */
// ----------------------------------------------------------------------------
// Worker queue package
// Sizes, codes and payload types shared by the worker queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wql_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int ID_W      = 16;
   localparam int TIME_W    = 32;
   localparam int OP_W      = 3;
   localparam int KIND_W    = 3;
   localparam int QCOUNT_W  = 5;
   localparam int INTV_W    = 16;
   localparam int LIVE_W    = 4;
   localparam int LIMIT_W   = INTV_W + LIVE_W;
   localparam int CSR_IDX_W = 1;

   localparam logic [INTV_W-1:0] INTERVAL_RESET = 16'd1000;
   localparam logic [LIVE_W-1:0] LIVENESS_RESET = 4'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HB_INTERVAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIVENESS    = 1'd1;

   // input opcodes
   localparam logic [OP_W-1:0] OP_READY     = 3'd0;
   localparam logic [OP_W-1:0] OP_HEARTBEAT = 3'd1;
   localparam logic [OP_W-1:0] OP_REPLY     = 3'd2;
   localparam logic [OP_W-1:0] OP_REQUEST   = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK      = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_DONE      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FORWARD   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ROUTE     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NO_WORKER = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 3'd5;
   localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd6;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic [ID_W-1:0] worker_id;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [ID_W-1:0]     target_id;
      logic [QCOUNT_W-1:0] queue_count;
      logic                last;
   } rsp_payload_type;

   // one queue slot
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   // write command into the queue store
   typedef struct packed {
      logic              id_en;
      logic              stamp_en;
      logic [IDX_W-1:0]  addr;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] stamp;
   } store_wr_type;

endpackage

`default_nettype wire

/* rtl/core/wql_store.sv */
// ----------------------------------------------------------------------------
// Worker queue store
// Register file of worker ids and stamps, one write port and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wql_store (
   input  wire logic                      clock,
   input  wire wql_pkg::store_wr_type     wr,
   input  wire logic [wql_pkg::IDX_W-1:0] rd_addr,
   output wql_pkg::entry_type             rd_entry
);
   import wql_pkg::*;

   logic [ID_W-1:0]   id_mem    [QUEUE_DEPTH];
   logic [TIME_W-1:0] stamp_mem [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.id_en) begin
         id_mem[wr.addr] <= wr.id;
      end
      if (wr.stamp_en) begin
         stamp_mem[wr.addr] <= wr.stamp;
      end
   end

   assign rd_entry.id    = id_mem[rd_addr];
   assign rd_entry.stamp = stamp_mem[rd_addr];

endmodule

`default_nettype wire

/* rtl/core/worker_queue_with_liveness_top.sv */
// ----------------------------------------------------------------------------
// Worker queue with liveness
// Ordered idle-worker queue with last-seen stamps, heartbeat rounds and expiry.
// ----------------------------------------------------------------------------
// req_* carries one message (opcode, worker_id) per transfer; rsp_* returns one
// or more results per message, the final one flagged by last. csr_* writes the
// heartbeat interval (index 0) and liveness count (index 1); the user must
// write them only while idle, as the block does not enforce it. One message
// at a time: req_ready is high only between messages. A sequencer walks the
// queue one entry per cycle through the store's read port, unless a stalled
// output holds it. A ready, heartbeat or reply searches the queue, a request
// pops its head, and a tick runs a heartbeat round when due, then an expiry
// pass closing the gap behind each expired worker. Results trail by one step
// so that last can be marked; the final result is offered as req_ready returns.
// Reset empties the queue, clears time and the heartbeat mark, and loads
// interval 1000 and liveness 3; no clearing pass is needed.
// A stalled receiver holds the output register; the sequencer stops at its
// next result and nothing is lost or reordered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "worker_queue_with_liveness_top_defines.svh"

module worker_queue_with_liveness_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire wql_pkg::req_payload_type      req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output wql_pkg::rsp_payload_type           rsp_payload,
   input  wire logic                          csr_we,
   input  wire logic [wql_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [wql_pkg::INTV_W-1:0]    csr_wdata
);
   import wql_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SHIFT,
      ST_APPEND,
      ST_EMIT_FULL,
      ST_HB,
      ST_EXPIRE,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in, ret_ff, ret_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [CNT_W-1:0]     shift_ff, shift_in;
   logic [CNT_W-1:0]     occ_ff, occ_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [TIME_W-1:0]    last_hb_ff, last_hb_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [INTV_W-1:0]    interval_ff, interval_in;
   logic [LIVE_W-1:0]    liveness_ff, liveness_in;
   logic                 pend_valid_ff, pend_valid_in;
   rsp_payload_type      pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   store_wr_type         wr;
   logic [IDX_W-1:0]     rd_addr;
   entry_type            rd;

   logic                 out_free;
   logic                 emit_ok;
   logic                 emit_en;
   rsp_payload_type      emit_item;
   logic                 flush_en;
   logic [CNT_W-1:0]     scan_next;
   logic [CNT_W-1:0]     shift_next;
   logic [CNT_W-1:0]     occ_dec;
   logic [TIME_W-1:0]    time_next;
   logic [TIME_W-1:0]    age;
   logic                 queue_full;
   logic                 scan_end;

   function automatic rsp_payload_type make_item(input logic [KIND_W-1:0] kind,
                                                 input logic [ID_W-1:0]   id,
                                                 input logic [CNT_W-1:0]  count);
      rsp_payload_type item;
      item.kind        = kind;
      item.target_id   = id;
      item.queue_count = QCOUNT_W'(count);
      item.last        = 1'b0;
      return item;
   endfunction

   wql_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_entry (rd)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign emit_ok    = !pend_valid_ff || out_free;
   assign scan_next  = scan_ff + CNT_W'(1);
   assign shift_next = shift_ff + CNT_W'(1);
   assign occ_dec    = occ_ff - CNT_W'(1);
   assign time_next  = time_ff + TIME_W'(1);
   assign age        = time_ff - rd.stamp;
   assign queue_full = (occ_ff == CNT_W'(QUEUE_DEPTH));
   assign scan_end   = (scan_ff == occ_ff);

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      scan_in       = scan_ff;
      shift_in      = shift_ff;
      occ_in        = occ_ff;
      time_in       = time_ff;
      last_hb_in    = last_hb_ff;
      limit_in      = limit_ff;
      interval_in   = interval_ff;
      liveness_in   = liveness_ff;
      emit_en       = 1'b0;
      emit_item     = make_item(KIND_DONE, '0, occ_ff);
      flush_en      = 1'b0;
      wr            = '0;
      rd_addr       = scan_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (req_valid) begin
               op_in   = req_payload.opcode;
               id_in   = req_payload.worker_id;
               scan_in = '0;
               unique case (req_payload.opcode) inside
                  OP_READY, OP_HEARTBEAT, OP_REPLY: begin
                     state_in = ST_FIND;
                  end
                  OP_REQUEST: begin
                     if (occ_ff != '0) begin
                        // pop the head: report it, then close the gap
                        emit_en   = 1'b1;
                        emit_item = make_item(KIND_ROUTE, rd.id, occ_dec);
                        shift_in  = '0;
                        ret_in    = ST_FINISH;
                        state_in  = ST_SHIFT;
                     end else begin
                        emit_en   = 1'b1;
                        emit_item = make_item(KIND_NO_WORKER, '0, occ_ff);
                        state_in  = ST_FINISH;
                     end
                  end
                  OP_TICK: begin
                     time_in  = time_next;
                     limit_in = LIMIT_W'(liveness_ff) * LIMIT_W'(interval_ff);
                     if ((time_next - last_hb_ff) > TIME_W'(interval_ff)) begin
                        last_hb_in = time_next;
                        state_in   = ST_HB;
                     end else begin
                        state_in = ST_EXPIRE;
                     end
                  end
                  default: begin
                     emit_en   = 1'b1;
                     emit_item = make_item(KIND_DONE, '0, occ_ff);
                     state_in  = ST_FINISH;
                  end
               endcase
            end
         end

         ST_FIND: begin
            if (scan_end) begin
               unique case (op_ff)
                  OP_READY: begin
                     if (queue_full) begin
                        emit_en   = 1'b1;
                        emit_item = make_item(KIND_FULL, id_ff, occ_ff);
                        state_in  = ST_FINISH;
                     end else begin
                        state_in = ST_APPEND;
                     end
                  end
                  OP_HEARTBEAT: begin
                     emit_en   = 1'b1;
                     emit_item = make_item(KIND_UNKNOWN, id_ff, occ_ff);
                     state_in  = ST_FINISH;
                  end
                  default: begin
                     emit_en   = 1'b1;
                     emit_item = make_item(KIND_FORWARD, id_ff, occ_ff);
                     state_in  = queue_full ? ST_EMIT_FULL : ST_APPEND;
                  end
               endcase
            end else if (rd.id == id_ff) begin
               unique case (op_ff)
                  OP_READY: begin
                     // remove, then append with a fresh stamp
                     shift_in = scan_ff;
                     ret_in   = ST_APPEND;
                     state_in = ST_SHIFT;
                  end
                  OP_HEARTBEAT: begin
                     wr.stamp_en = 1'b1;
                     wr.addr     = scan_ff[IDX_W-1:0];
                     wr.stamp    = time_ff;
                     emit_en     = 1'b1;
                     emit_item   = make_item(KIND_DONE, id_ff, occ_ff);
                     state_in    = ST_FINISH;
                  end
                  default: begin
                     emit_en   = 1'b1;
                     emit_item = make_item(KIND_FORWARD, id_ff, occ_ff);
                     state_in  = ST_FINISH;
                  end
               endcase
            end else begin
               scan_in = scan_next;
            end
         end

         ST_SHIFT: begin
            rd_addr = shift_next[IDX_W-1:0];
            if (shift_next < occ_ff) begin
               wr.id_en    = 1'b1;
               wr.stamp_en = 1'b1;
               wr.addr     = shift_ff[IDX_W-1:0];
               wr.id       = rd.id;
               wr.stamp    = rd.stamp;
               shift_in    = shift_next;
            end else begin
               occ_in   = occ_dec;
               state_in = ret_ff;
            end
         end

         ST_APPEND: begin
            wr.id_en    = 1'b1;
            wr.stamp_en = 1'b1;
            wr.addr     = occ_ff[IDX_W-1:0];
            wr.id       = id_ff;
            wr.stamp    = time_ff;
            occ_in      = occ_ff + CNT_W'(1);
            if (op_ff == OP_READY) begin
               emit_en   = 1'b1;
               emit_item = make_item(KIND_DONE, id_ff, occ_ff + CNT_W'(1));
            end
            state_in = ST_FINISH;
         end

         ST_EMIT_FULL: begin
            if (emit_ok) begin
               emit_en   = 1'b1;
               emit_item = make_item(KIND_FULL, id_ff, occ_ff);
               state_in  = ST_FINISH;
            end
         end

         ST_HB: begin
            if (scan_end) begin
               scan_in  = '0;
               state_in = ST_EXPIRE;
            end else if (emit_ok) begin
               emit_en   = 1'b1;
               emit_item = make_item(KIND_HEARTBEAT, rd.id, occ_ff);
               scan_in   = scan_next;
            end
         end

         ST_EXPIRE: begin
            if (scan_end) begin
               // quiet tick still answers once
               if (!pend_valid_ff) begin
                  emit_en   = 1'b1;
                  emit_item = make_item(KIND_DONE, '0, occ_ff);
               end
               state_in = ST_FINISH;
            end else if (age > TIME_W'(limit_ff)) begin
               if (emit_ok) begin
                  emit_en   = 1'b1;
                  emit_item = make_item(KIND_EXPIRED, rd.id, occ_dec);
                  shift_in  = scan_ff;
                  ret_in    = ST_EXPIRE;
                  state_in  = ST_SHIFT;
               end
            end else begin
               scan_in = scan_next;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               flush_en = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // config writes must arrive only while idle; the block does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            CSR_HB_INTERVAL: interval_in = csr_wdata;
            CSR_LIVENESS:    liveness_in = csr_wdata[LIVE_W-1:0];
            default:         interval_in = interval_ff;
         endcase
      end
   end

   // one result is held back so that last can be set on the final one
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (emit_en) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_valid_in = 1'b1;
         end
         pend_in       = emit_item;
         pend_valid_in = 1'b1;
      end else if (flush_en) begin
         rsp_in        = pend_ff;
         rsp_in.last   = 1'b1;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      op_ff    <= op_in;
      id_ff    <= id_in;
      scan_ff  <= scan_in;
      shift_ff <= shift_in;
      limit_ff <= limit_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         time_ff       <= '0;
         last_hb_ff    <= '0;
         interval_ff   <= INTERVAL_RESET;
         liveness_ff   <= LIVENESS_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         time_ff       <= time_in;
         last_hb_ff    <= last_hb_in;
         interval_ff   <= interval_in;
         liveness_ff   <= liveness_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   `WQL_ASSERT_ALWAYS(a_occ_bound, clock, reset, occ_ff <= CNT_W'(QUEUE_DEPTH))
   `WQL_ASSERT_ALWAYS(a_idle_no_pend, clock, reset, (state_ff != ST_IDLE) || !pend_valid_ff)
   `WQL_ASSERT_ALWAYS(a_shift_range, clock, reset, (state_ff != ST_SHIFT) || (shift_ff < occ_ff))
   `WQL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Worker queue with liveness testbench
// Drives ready, heartbeat, reply, request and tick messages with random
// handshake gaps and compares every result with a cycle-free model of the
// idle-worker queue, across several heartbeat and liveness settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import wql_pkg::*;

   localparam int IDLE_LIMIT      = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 60;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 51;
   localparam int POOL_SIZE       = 24;

   // opcodes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_payload_type      req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_payload_type      rsp_payload;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [INTV_W-1:0]    csr_wdata;

   bit                   running;
   bit                   calm;
   bit                   hold_off_armed;
   bit                   hold_off_done;
   int                   idle_cycles = 0;
   logic [ID_W-1:0]      id_pool [POOL_SIZE];
   logic [INTV_W-1:0]    phase_interval [RANDOM_PHASES];
   logic [INTV_W-1:0]    phase_liveness [RANDOM_PHASES];

   class idle_worker_ledger;
      logic [ID_W-1:0]   idle_ids [QUEUE_DEPTH];
      logic [TIME_W-1:0] seen_at  [QUEUE_DEPTH];
      int                n_idle;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] last_round;
      logic [INTV_W-1:0] interval;
      logic [LIVE_W-1:0] liveness;
      rsp_payload_type   owed_results [$];
      rsp_payload_type   batch [$];
      int                mismatches;

      function new();
         interval   = INTERVAL_RESET;
         liveness   = LIVENESS_RESET;
         n_idle     = 0;
         now_ms     = '0;
         last_round = '0;
         mismatches = 0;
      endfunction

      function void write_setting(logic [CSR_IDX_W-1:0] index, logic [INTV_W-1:0] data);
         if (index == CSR_HB_INTERVAL) begin
            interval = data;
         end else begin
            liveness = data[LIVE_W-1:0];
         end
      endfunction

      function int find_worker(logic [ID_W-1:0] id);
         for (int i = 0; i < n_idle; i++) begin
            if (idle_ids[i] == id) return i;
         end
         return -1;
      endfunction

      function void drop_at(int pos);
         for (int i = pos; i + 1 < n_idle; i++) begin
            idle_ids[i] = idle_ids[i + 1];
            seen_at[i]  = seen_at[i + 1];
         end
         n_idle--;
      endfunction

      function bit append_worker(logic [ID_W-1:0] id);
         if (n_idle >= QUEUE_DEPTH) return 1'b0;
         idle_ids[n_idle] = id;
         seen_at[n_idle]  = now_ms;
         n_idle++;
         return 1'b1;
      endfunction

      function void add(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id);
         rsp_payload_type r;
         r.kind        = kind;
         r.target_id   = id;
         r.queue_count = QCOUNT_W'(n_idle);
         r.last        = 1'b0;
         batch = {batch, r};
      endfunction

      function void apply_message(req_payload_type m);
         int                pos;
         int                i;
         logic [TIME_W-1:0] limit;
         logic [ID_W-1:0]   gone;
         batch.delete();
         case (m.opcode)
            OP_READY: begin
               pos = find_worker(m.worker_id);
               if (pos >= 0) drop_at(pos);
               if (append_worker(m.worker_id)) add(KIND_DONE, m.worker_id);
               else add(KIND_FULL, m.worker_id);
            end
            OP_HEARTBEAT: begin
               pos = find_worker(m.worker_id);
               if (pos >= 0) begin
                  seen_at[pos] = now_ms;
                  add(KIND_DONE, m.worker_id);
               end else begin
                  add(KIND_UNKNOWN, m.worker_id);
               end
            end
            OP_REPLY: begin
               // count on the forward is taken before any append
               add(KIND_FORWARD, m.worker_id);
               if (find_worker(m.worker_id) < 0 && !append_worker(m.worker_id))
                  add(KIND_FULL, m.worker_id);
            end
            OP_REQUEST: begin
               if (n_idle > 0) begin
                  gone = idle_ids[0];
                  drop_at(0);
                  add(KIND_ROUTE, gone);
               end else begin
                  add(KIND_NO_WORKER, '0);
               end
            end
            OP_TICK: begin
               limit  = TIME_W'(liveness) * TIME_W'(interval);
               now_ms = now_ms + 1;
               if (now_ms - last_round > TIME_W'(interval)) begin
                  for (i = 0; i < n_idle; i++) add(KIND_HEARTBEAT, idle_ids[i]);
                  last_round = now_ms;
               end
               i = 0;
               while (i < n_idle) begin
                  if (now_ms - seen_at[i] > limit) begin
                     gone = idle_ids[i];
                     drop_at(i);
                     add(KIND_EXPIRED, gone);
                  end else begin
                     i++;
                  end
               end
               if (batch.size() == 0) add(KIND_DONE, '0);
            end
            default: add(KIND_DONE, '0);
         endcase
         batch[batch.size() - 1].last = 1'b1;
         owed_results = {owed_results, batch};
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
      endtask

      task match_result(rsp_payload_type got);
         rsp_payload_type want;
         if (owed_results.size() == 0) begin
            report($sformatf("unexpected result kind %0d id %h count %0d last %b",
                             got.kind, got.target_id, got.queue_count, got.last));
            return;
         end
         want = owed_results.pop_front();
         if (got.kind !== want.kind || got.target_id !== want.target_id ||
             got.queue_count !== want.queue_count || got.last !== want.last)
            report($sformatf("kind %0d/%0d id %h/%h count %0d/%0d last %b/%b (got/exp)",
                             got.kind, want.kind, got.target_id, want.target_id,
                             got.queue_count, want.queue_count, got.last, want.last));
      endtask

      function int pending();
         return owed_results.size();
      endfunction
   endclass

   idle_worker_ledger ledger;

   worker_queue_with_liveness_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int draw_gap();
      return calm ? 0 : int'($urandom_range(0, 7));
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 9) == 0) return ID_W'($urandom);
      return id_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
      req_payload_type item;
      int              gap;
      item.opcode    = op;
      item.worker_id = id;
      gap            = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      ledger.apply_message(item);
   endtask

   // wait for the block to go quiet, then load both registers
   task automatic configure(input logic [INTV_W-1:0] interval,
                            input logic [INTV_W-1:0] live_data);
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_HB_INTERVAL;
      csr_wdata <= interval;
      @(posedge clock);
      ledger.write_setting(CSR_HB_INTERVAL, interval);
      csr_index <= CSR_LIVENESS;
      csr_wdata <= live_data;
      @(posedge clock);
      ledger.write_setting(CSR_LIVENESS, live_data);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int                roll;
      bit                fill;
      logic [OP_W-1:0]   op;
      ledger = new();
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom);
      phase_interval = '{16'd1, 16'd3, 16'd2, 16'd65535, 16'd4, 16'd0, 16'd1, 16'd5};
      phase_liveness = '{16'd1, 16'd2, 16'd15, 16'd15, 16'hFFF2, 16'd3, 16'd0, 16'd2};
      phase_interval[RANDOM_PHASES - 1] = INTV_W'($urandom_range(1, 8));
      phase_liveness[RANDOM_PHASES - 1] = INTV_W'($urandom);

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_HB_INTERVAL;
      csr_wdata   <= '0;
      repeat (11) @(posedge clock);
      reset   <= 1'b0;
      running = 1'b1;

      // reset settings: empty queue, moves, stamps, no-op opcodes
      send_item(OP_REQUEST, 16'h0000);
      send_item(OP_HEARTBEAT, 16'h1234);
      send_item(OP_READY, 16'h0000);
      send_item(OP_READY, 16'hFFFF);
      send_item(OP_READY, 16'h0000);
      send_item(OP_HEARTBEAT, 16'hFFFF);
      send_item(OP_REPLY, 16'hFFFF);
      send_item(OP_REPLY, 16'h5A5A);
      send_item(OP_TICK, 16'hFFFF);
      send_item(OP_REQUEST, 16'hFFFF);
      send_item(OP_UNUSED_LO, 16'hFFFF);
      send_item(OP_UNUSED_LO + 3'd1, pick_id());
      send_item(OP_UNUSED_HI, 16'h0000);

      // zero interval and zero liveness: a round and full expiry on each tick
      configure('0, '0);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_READY, 16'h00FF);
      send_item(OP_READY, 16'hFF00);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_REPLY, 16'hA5A5);
      send_item(OP_REQUEST, 16'h0000);
      send_item(OP_REQUEST, 16'h0000);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         configure(phase_interval[ph], phase_liveness[ph]);
         calm = (ph % 3 == 2);
         fill = (ph % 2 == 1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 1 && k == 10) hold_off_armed = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < (fill ? 40 : 25)) op = OP_READY;
            else if (roll < (fill ? 50 : 40)) op = OP_HEARTBEAT;
            else if (roll < (fill ? 72 : 55)) op = OP_REPLY;
            else if (roll < (fill ? 80 : 70)) op = OP_REQUEST;
            else if (roll < 95) op = OP_TICK;
            else op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            send_item(op, pick_id());
         end
      end

      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : results
      int wait_cycles;
      rsp_ready <= 1'b0;
      wait (running);
      forever begin
         // one long hold-off so the block backs up onto its input
         if (hold_off_armed && !hold_off_done) begin
            wait_cycles   = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
         end else begin
            wait_cycles = draw_gap();
         end
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         ledger.match_result(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule

/* worker_queue_with_liveness_top.f */
+incdir+rtl/core
rtl/core/wql_pkg.sv
rtl/core/wql_store.sv
rtl/core/worker_queue_with_liveness_top.sv
dv/testbench.sv
